// ===== hw/rtl/sbs_pkg.sv =====
// shared types and constants for the sorted table binary search block
package sbs_pkg;

	localparam int KEY_W   = 32;
	localparam int VAL_W   = 32;
	localparam int INDEX_W = 10;
	localparam int COUNT_W = 11;

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	// input word
	typedef struct packed {
		logic               op;
		logic [INDEX_W-1:0] entry_index;
		logic [KEY_W-1:0]   key;
		logic [VAL_W-1:0]   entry_offset;
		logic [VAL_W-1:0]   entry_length;
	} in_word_t;

	// result word
	typedef struct packed {
		logic             hit;
		logic [VAL_W-1:0] found_offset;
		logic [VAL_W-1:0] found_length;
	} out_word_t;

	// one table entry
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] offset;
		logic [VAL_W-1:0] length;
	} entry_t;

	// controller to datapath
	typedef struct packed {
		logic wr_en;
		logic init;
		logic step;
		logic res_hit;
		logic res_miss;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic empty;
		logic eq;
		logic next_empty;
	} sts_t;

endpackage

// ===== hw/rtl/sbs_ctrl.sv =====
// search controller: idle / probe state machine
module sbs_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          op,
	input  sbs_pkg::sts_t sts,
	output sbs_pkg::cmd_t cmd,
	output logic          busy,
	output logic          done
);

	typedef enum logic {
		ST_IDLE,
		ST_PROBE
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   done_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (op == sbs_pkg::OP_LOAD) begin
						cmd.wr_en = 1'b1;
					end else begin
						cmd.init = 1'b1;
						if (sts.empty) begin
							cmd.res_miss = 1'b1;
						end else begin
							state_d = ST_PROBE;
						end
					end
				end
			end
			ST_PROBE: begin
				cmd.step = 1'b1;
				if (sts.eq) begin
					cmd.res_hit = 1'b1;
					state_d     = ST_IDLE;
				end else if (sts.next_empty) begin
					cmd.res_miss = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.res_hit | cmd.res_miss;
		end
	end

	assign busy = (state_q == ST_PROBE);
	assign done = done_q;

endmodule

// ===== hw/rtl/sbs_dp.sv =====
// search datapath: index table memory, search bounds, compare and result register
module sbs_dp #(
	parameter int MAX_ENTRIES = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [sbs_pkg::COUNT_W-1:0]  cfg_data,
	input  sbs_pkg::in_word_t            item,
	input  sbs_pkg::cmd_t                cmd,
	output sbs_pkg::sts_t                sts,
	output sbs_pkg::out_word_t           result
);

	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = sbs_pkg::COUNT_W;

	sbs_pkg::entry_t    tbl_q [MAX_ENTRIES];
	sbs_pkg::entry_t    rd_q;
	sbs_pkg::out_word_t res_q;

	logic [CW-1:0]                 count_q;
	logic [CW-1:0]                 count_sat;
	logic [CW-1:0]                 lo_q, hi_q, mid_q;
	logic [CW-1:0]                 lo_n, hi_n, mid_n;
	logic [CW:0]                   sum;
	logic [sbs_pkg::KEY_W-1:0]     key_q;
	logic [AW-1:0]                 rd_addr;
	logic                          wr_ok;
	logic                          lt;

	assign count_sat = (int'(count_q) > MAX_ENTRIES) ? CW'(MAX_ENTRIES) : count_q;
	assign wr_ok     = cmd.wr_en && (int'(item.entry_index) < MAX_ENTRIES);
	assign lt        = key_q < rd_q.key;

	// next bounds, inclusive low / exclusive high
	always_comb begin
		lo_n = lo_q;
		hi_n = hi_q;
		if (cmd.init) begin
			lo_n = '0;
			hi_n = count_sat;
		end else if (cmd.step) begin
			if (lt) begin
				hi_n = mid_q;
			end else begin
				lo_n = mid_q + CW'(1);
			end
		end
	end

	assign sum     = {1'b0, lo_n} + {1'b0, hi_n} - (CW+1)'(1);
	assign mid_n   = CW'(sum >> 1);
	assign rd_addr = AW'(mid_n);

	assign sts.empty      = (count_sat == '0);
	assign sts.eq         = (key_q == rd_q.key);
	assign sts.next_empty = lt ? (lo_q >= mid_q) : ((mid_q + CW'(1)) >= hi_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg_we) begin
			count_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			tbl_q[AW'(item.entry_index)] <= '{key:    item.key,
			                                 offset: item.entry_offset,
			                                 length: item.entry_length};
		end
		rd_q <= tbl_q[rd_addr];
	end

	always_ff @(posedge clk) begin
		lo_q  <= lo_n;
		hi_q  <= hi_n;
		mid_q <= mid_n;
		if (cmd.init) begin
			key_q <= item.key;
		end
		if (cmd.res_hit || cmd.res_miss) begin
			res_q.hit          <= cmd.res_hit;
			res_q.found_offset <= cmd.res_hit ? rd_q.offset : '0;
			res_q.found_length <= cmd.res_hit ? rd_q.length : '0;
		end
	end

	assign result = res_q;

endmodule

// ===== hw/rtl/sorted_table_binary_search_top.sv =====
// top level of the sorted table binary search block
// load word: written to the table at its accept edge, busy stays low
// lookup word: one probe per cycle on the registered table read, k probes, k <= 11 for 1024
// entries (floor(log2(entry_count)) + 1), busy high while probing, done pulses in the cycle
// after the last probe; empty table: miss strobed in the cycle after accept
// reset (arst_n low) clears controller state and entry_count; table content is undefined
module sorted_table_binary_search_top #(
	parameter int MAX_ENTRIES = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// command side
	input  logic                         start,
	output logic                         busy,
	input  sbs_pkg::in_word_t            item,
	// result side, one word per lookup
	output logic                         done,
	output sbs_pkg::out_word_t           result,
	// entry_count register write channel
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [sbs_pkg::COUNT_W-1:0]  cfg_data
);

	sbs_pkg::cmd_t cmd;
	sbs_pkg::sts_t sts;

	// register writes land directly, no back-pressure needed
	assign cfg_ready = 1'b1;

	// controller: sequences the probes and raises the result strobe
	sbs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (item.op),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// datapath: table memory, bounds, key compare, result word
	sbs_dp #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid & cfg_ready),
		.cfg_data (cfg_data),
		.item     (item),
		.cmd      (cmd),
		.sts      (sts),
		.result   (result)
	);

`ifndef SYNTH
	// a result word is only strobed once the search has finished
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobed while search still running");

	// a miss carries zero offset and length
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.hit) |-> (result.found_offset == '0 && result.found_length == '0))
		else $error("miss word with nonzero payload");

	// a search only starts from an accepted lookup word
	a_busy_from_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> ($past(start) && $past(item.op == sbs_pkg::OP_LOOKUP)))
		else $error("search started without a lookup word");

	// a running search either continues or delivers its word
	a_no_lost_result: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> (busy || done))
		else $error("search ended without a result word");
`endif

endmodule

// ===== tb/sv/tb_sorted_table_binary_search_top.sv =====
// self-checking testbench for the sorted table binary search block
module tb_sorted_table_binary_search_top;
	import sbs_pkg::*;

	localparam int MAX_ENTRIES   = 1024;
	// a full-table lookup is at most 11 probes plus the result strobe, so SETTLE_CYCLES covers any word in flight
	localparam int SETTLE_CYCLES = 16;
	// slowest legal stretch without a handshake stays well under STALL_LIMIT
	// (a send gap, a full lookup, drain and settle before a register write)
	localparam int STALL_LIMIT   = 4000;

	typedef enum logic {ROW_CFG, ROW_WORD} row_kind_e;

	// one line of the directed table: a register write or a command word
	typedef struct {
		row_kind_e   kind;
		int unsigned count;
		in_word_t    word;
		bit          typed;
		out_word_t   want;
	} row_t;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	in_word_t            item;
	logic                done;
	out_word_t           result;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [COUNT_W-1:0]  cfg_data;

	// shadow copy of the index table and of entry_count
	entry_t      table_copy [MAX_ENTRIES];
	int unsigned count_copy;
	// lookups accepted whose result word has not come back yet, oldest first
	out_word_t   pending_results [$];
	row_t        rows [$];
	int          errors = 0;
	int          words_sent = 0;
	int          filled = 0;
	int          idle_cycles = 0;
	bit          burst = 1'b0;

	sorted_table_binary_search_top #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.item     (item),
		.done     (done),
		.result   (result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// number of entries the search really covers, counts above the table size saturate
	function automatic int searched_entries();
		return (count_copy > MAX_ENTRIES) ? MAX_ENTRIES : int'(count_copy);
	endfunction

	// binary search over the shadow table, middle rounded down, same probe order as the block
	function automatic out_word_t search_table(logic [KEY_W-1:0] key);
		int        lo;
		int        hi;
		int        mid;
		out_word_t r;
		r  = '0;
		lo = 0;
		hi = searched_entries() - 1;
		while (lo <= hi) begin
			mid = (lo + hi) / 2;
			if (key == table_copy[mid].key) begin
				r.hit          = 1'b1;
				r.found_offset = table_copy[mid].offset;
				r.found_length = table_copy[mid].length;
				return r;
			end
			if (key < table_copy[mid].key)
				hi = mid - 1;
			else
				lo = mid + 1;
		end
		return r;
	endfunction

	function automatic void add_cfg(int unsigned v);
		row_t r;
		r.kind  = ROW_CFG;
		r.count = v;
		r.word  = '0;
		r.typed = 1'b0;
		r.want  = '0;
		rows.push_back(r);
	endfunction

	function automatic void add_load(logic [INDEX_W-1:0] idx, logic [KEY_W-1:0] k,
		logic [VAL_W-1:0] off, logic [VAL_W-1:0] len);
		row_t r;
		r.kind  = ROW_WORD;
		r.count = 0;
		r.word  = '{op: OP_LOAD, entry_index: idx, key: k, entry_offset: off,
			entry_length: len};
		r.typed = 1'b0;
		r.want  = '0;
		rows.push_back(r);
	endfunction

	// typed = 1 takes the expected word from the table, otherwise the shadow search decides
	function automatic void add_find(logic [KEY_W-1:0] k, bit typed = 1'b0,
		out_word_t want = '0);
		row_t r;
		r.kind  = ROW_WORD;
		r.count = 0;
		r.word  = '{op: OP_LOOKUP, entry_index: '0, key: k, entry_offset: '0,
			entry_length: '0};
		r.typed = typed;
		r.want  = want;
		rows.push_back(r);
	endfunction

	// present one word after a random gap (none in burst mode) and hold it until the block takes it
	task automatic send_word(in_word_t w, bit typed, out_word_t want);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start <= 1'b1;
		item  <= w;
		@(posedge clk);
		while (busy !== 1'b0) @(posedge clk);
		// word taken at this edge: update the shadow state or queue the answer
		words_sent++;
		if (w.op == OP_LOOKUP)
			pending_results.push_back(typed ? want : search_table(w.key));
		else
			table_copy[w.entry_index] = '{key: w.key, offset: w.entry_offset,
				length: w.entry_length};
	endtask

	// stop sending, wait for every result word, then let a trailing lookup die out
	task automatic settle();
		@(negedge clk);
		start <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// entry_count is only written with the block idle
	task automatic set_entry_count(int unsigned v);
		settle();
		cfg_valid <= 1'b1;
		cfg_data  <= COUNT_W'(v);
		@(posedge clk);
		while (cfg_ready !== 1'b1) @(posedge clk);
		count_copy = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// mostly keys that are in the searched range, some neighbors, extremes and noise
	function automatic logic [KEY_W-1:0] pick_key();
		int eff;
		int sel;
		eff = searched_entries();
		sel = $urandom_range(0, 9);
		if (eff > 0 && sel < 6)
			return table_copy[$urandom_range(0, eff - 1)].key;
		if (eff > 0 && sel < 8)
			return table_copy[$urandom_range(0, eff - 1)].key
				+ ($urandom_range(0, 1) ? 32'h0000_0001 : 32'hFFFF_FFFF);
		if (sel == 8)
			return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
		return $urandom();
	endfunction

	// write entries 0..n-1, ascending keys unless sorted is clear
	task automatic load_table(int n, bit sorted);
		longint unsigned step;
		logic [KEY_W-1:0] k;
		in_word_t         w;
		step = 64'hFFFF_FFFF / (n + 1);
		k    = ($urandom_range(0, 3) == 0) ? 32'h0 : $urandom_range(0, step);
		for (int i = 0; i < n; i++) begin
			// occasional repeated key, increments never run past the top
			if (i > 0)
				k = k + (($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, step));
			if (i == n - 1 && $urandom_range(0, 3) == 0)
				k = 32'hFFFF_FFFF;
			w.op           = OP_LOAD;
			w.entry_index  = INDEX_W'(i);
			w.key          = sorted ? k : $urandom();
			w.entry_offset = $urandom();
			w.entry_length = $urandom();
			send_word(w, 1'b0, '0);
		end
		if (n > filled)
			filled = n;
	endtask

	// lookups with some loads mixed in that leave the searched range in order
	task automatic lookup_burst(int m);
		in_word_t w;
		int       eff;
		for (int i = 0; i < m; i++) begin
			eff = searched_entries();
			// now and then the sender waits for every result before going on
			if ($urandom_range(0, 39) == 0)
				settle();
			w.entry_offset = $urandom();
			w.entry_length = $urandom();
			if ($urandom_range(0, 9) == 0) begin
				w.op = OP_LOAD;
				if (eff > 0 && (eff == MAX_ENTRIES || $urandom_range(0, 1) == 1)) begin
					// rewrite payload in place, key unchanged so the order holds
					w.entry_index = INDEX_W'($urandom_range(0, eff - 1));
					w.key         = table_copy[w.entry_index].key;
				end else begin
					w.entry_index = INDEX_W'($urandom_range(eff, MAX_ENTRIES - 1));
					w.key         = $urandom();
				end
			end else begin
				w.op          = OP_LOOKUP;
				w.entry_index = INDEX_W'($urandom());
				w.key         = pick_key();
			end
			send_word(w, 1'b0, '0);
		end
	endtask

	// result checker: every strobed word must match the oldest queued answer
	always @(posedge clk) begin
		out_word_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: result word with none expected: hit %b offset %h length %h",
					$time, result.hit, result.found_offset, result.found_length);
			end else begin
				want = pending_results.pop_front();
				if (result.hit !== want.hit) begin
					errors++;
					$display("%0t: hit expected %b actual %b", $time, want.hit, result.hit);
				end
				if (result.found_offset !== want.found_offset) begin
					errors++;
					$display("%0t: found_offset expected %h actual %h", $time,
						want.found_offset, result.found_offset);
				end
				if (result.found_length !== want.found_length) begin
					errors++;
					$display("%0t: found_length expected %h actual %h", $time,
						want.found_length, result.found_length);
				end
			end
		end
	end

	// watchdog: any handshake on any port restarts the count
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == STALL_LIMIT) begin
			$display("tb_sorted_table_binary_search_top: FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int n;
		start      = 1'b0;
		item       = '0;
		cfg_valid  = 1'b0;
		cfg_data   = '0;
		arst_n     = 1'b0;
		count_copy = 0;

		// directed table
		// empty table right after reset: both key extremes miss
		add_find(32'h0000_0000, 1'b1, '0);
		add_find(32'hFFFF_FFFF, 1'b1, '0);
		// four sorted entries spanning the key range, plus the top table slot
		add_load(10'd0, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000);
		add_load(10'd1, 32'h0000_1000, 32'h0000_0001, 32'h0000_0002);
		add_load(10'd2, 32'h8000_0000, 32'h5A5A_5A5A, 32'hA5A5_A5A5);
		add_load(10'd3, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
		add_load(10'd1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add_cfg(4);
		// lowest and highest key hit the first and last entry
		add_find(32'h0000_0000, 1'b1, '{hit: 1'b1, found_offset: 32'hFFFF_FFFF,
			found_length: 32'h0000_0000});
		add_find(32'hFFFF_FFFF, 1'b1, '{hit: 1'b1, found_offset: 32'h0000_0000,
			found_length: 32'hFFFF_FFFF});
		add_find(32'h0000_1000);
		add_find(32'h8000_0000);
		add_find(32'h0000_0FFF);
		add_find(32'h8000_0001);
		// single entry: a key beyond the count is not seen
		add_cfg(1);
		add_find(32'h0000_0000);
		add_find(32'h0000_1000);
		// out-of-order entry: the search still walks the plain probe sequence
		add_load(10'd2, 32'h0000_0010, 32'h0000_0007, 32'h0000_0008);
		add_cfg(4);
		add_find(32'h0000_0010);
		add_find(32'hFFFF_FFFF);
		// back to empty with entries present
		add_cfg(0);
		add_find(32'h0000_1000, 1'b1, '0);

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (rows[i]) begin
			if (rows[i].kind == ROW_CFG)
				set_entry_count(rows[i].count);
			else
				send_word(rows[i].word, rows[i].typed, rows[i].want);
		end

		// random phases on small tables: load, set the count, search
		while (words_sent < 560) begin
			burst = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 5))
				0:       n = 1;
				1:       n = $urandom_range(2, 3);
				default: n = $urandom_range(4, 40);
			endcase
			load_table(n, $urandom_range(0, 7) != 0);
			set_entry_count(($urandom_range(0, 4) == 0) ? $urandom_range(0, filled) : n);
			lookup_burst($urandom_range(10, 30));
		end

		// whole table in order, then counts at and above the table size, then a count of zero
		burst = 1'b0;
		load_table(MAX_ENTRIES, 1'b1);
		set_entry_count(MAX_ENTRIES);
		lookup_burst(60);
		burst = 1'b1;
		set_entry_count(2047);
		lookup_burst(40);
		burst = 1'b0;
		set_entry_count($urandom_range(MAX_ENTRIES + 1, 2046));
		lookup_burst(30);
		set_entry_count(0);
		lookup_burst(10);

		settle();
		if (errors == 0)
			$display("tb_sorted_table_binary_search_top: PASS");
		else
			$display("tb_sorted_table_binary_search_top: FAIL");
		$finish;
	end

endmodule

// ===== sorted_table_binary_search_top.f =====
hw/rtl/sbs_pkg.sv
hw/rtl/sbs_ctrl.sv
hw/rtl/sbs_dp.sv
hw/rtl/sorted_table_binary_search_top.sv
tb/sv/tb_sorted_table_binary_search_top.sv
